// ===== rtl/core/r2o_pkg.sv =====
package r2o_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int GUARD_BITS = 6;
   localparam int ATAN_COUNT = 24;

   localparam int PIX_W    = 8;
   localparam int GAM_W    = FRAC_BITS + 1;
   localparam int LUMA_W   = 17;
   localparam int CHROMA_W = 18;
   localparam int PROD_W   = 33;
   localparam int CYB_W    = 34;
   localparam int CRG_W    = 35;
   localparam int VEC_W    = 26;
   localparam int ANG_W    = 34;
   localparam int GAIN_W   = 31;
   localparam int PX_W     = VEC_W + GAIN_W;

   localparam logic [15:0] LUMA_COEF_R = 16'd19595;
   localparam logic [15:0] LUMA_COEF_G = 16'd38470;
   localparam logic [15:0] LUMA_COEF_B = 16'd7471;
   localparam logic signed [16:0] CRG_COEF = 17'sd56754;
   localparam logic signed [GAIN_W-1:0] GAIN_INV = 31'sd652032874;

   localparam logic signed [ANG_W-1:0] ANG_PI_2 = 34'sd1686629713;
   localparam logic signed [ANG_W-1:0] ANG_PI_3 = 34'sd1124419809;
   localparam logic signed [ANG_W-1:0] ANG_PI_6 = 34'sd562209905;

   localparam logic signed [CHROMA_W-1:0] CHROMA_MAX = 18'sd131071;
   localparam logic signed [CHROMA_W-1:0] CHROMA_MIN = -18'sd131072;

   localparam logic signed [ANG_W-1:0] ATAN_Q30 [ATAN_COUNT] = '{
      34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
      34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
      34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
      34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
      34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
      34'sd1023,      34'sd511,       34'sd255,       34'sd127
   };

   typedef logic [GAM_W-1:0] gamma_type;
   typedef gamma_type gamma_rom_type [256];

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic signed [VEC_W-1:0] x0;
      logic signed [VEC_W-1:0] y0;
      logic [LUMA_W-1:0]       luma;
   } cordic_type;

   // largest y with (2y-1)^11 * 255^5 <= x^5 * 2^(11(F+1))
   function automatic gamma_rom_type build_gamma_rom();
      gamma_rom_type rom;
      logic [255:0] rhs;
      logic [255:0] lhs;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      for (int x = 0; x < 256; x++) begin
         rhs = 256'd1;
         for (int k = 0; k < 5; k++) rhs = rhs * 256'(x);
         rhs = rhs << (11 * (FRAC_BITS + 1));
         lo = 0;
         hi = 1 << FRAC_BITS;
         while (lo < hi) begin
            mid = lo + ((hi - lo + 1) >> 1);
            lhs = 256'd1;
            for (int k = 0; k < 11; k++) lhs = lhs * 256'(2 * mid - 1);
            for (int k = 0; k < 5; k++) lhs = lhs * 256'd255;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
         end
         rom[x] = GAM_W'(lo);
      end
      return rom;
   endfunction

   localparam gamma_rom_type GAMMA_ROM = build_gamma_rom();

endpackage

// ===== rtl/core/r2o_if.sv =====
interface r2o_req_if import r2o_pkg::*;;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red_in;
   logic [PIX_W-1:0] green_in;
   logic [PIX_W-1:0] blue_in;

   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface r2o_rsp_if import r2o_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [LUMA_W-1:0]          luma_out;
   logic signed [CHROMA_W-1:0] chroma_yb_out;
   logic signed [CHROMA_W-1:0] chroma_rg_out;

   modport source (output valid, luma_out, chroma_yb_out, chroma_rg_out, input ready);
   modport sink   (input valid, luma_out, chroma_yb_out, chroma_rg_out, output ready);
endinterface

// ===== rtl/core/rgb_to_orgb_pixel.sv =====
// stages from accepted word to result word: s1, s2, s3, cordics, gain, result
// throughput: one word per cycle; gamma rom, matrix, vectoring and rotation cordic
// are all fully pipelined, one register stage per cordic iteration
// the whole pipeline holds while the result register is full and not taken
// reset (synchronous) clears all valid bits; payload registers are not reset
module rgb_to_orgb_pixel
   import r2o_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  logic           clock,
   input  logic           reset,
   r2o_req_if.sink        req_chan,
   r2o_rsp_if.source      rsp_chan
);

   localparam int N = CORDIC_STAGES;

   logic adv;

   logic      s1_vld_ff;
   gamma_type s1_r_ff, s1_g_ff, s1_b_ff;

   logic                    s2_vld_ff;
   logic [PROD_W-1:0]       s2_lr_ff, s2_lg_ff, s2_lb_ff;
   logic signed [CYB_W-1:0] s2_cyb_ff;
   logic signed [CRG_W-1:0] s2_crg_ff;
   logic [GAM_W:0]          rg_sum;
   logic signed [GAM_W:0]   rg_diff;
   logic signed [CYB_W-1:0] s2_cyb_in;
   logic signed [CRG_W-1:0] s2_crg_in;

   logic                       s3_vld_ff;
   logic signed [VEC_W-1:0]    s3_x0_ff, s3_y0_ff;
   logic [LUMA_W-1:0]          s3_luma_ff;
   logic [CYB_W-1:0]           luma_sum;
   logic signed [CYB_W-1:0]    cyb_sum;
   logic signed [CRG_W-1:0]    crg_sum;
   logic signed [CHROMA_W-1:0] cyb_q, crg_q;

   logic [N:0] vec_vld_ff;
   cordic_type vec_ff [N+1];
   cordic_type vec_in;

   logic [N:0] rot_vld_ff;
   cordic_type rot_ff [N+1];
   cordic_type rot_in;
   logic signed [ANG_W-1:0] ang_abs;
   logic signed [ANG_W+1:0] ang_over, ang_tri, ang_d;

   logic                    gain_vld_ff;
   logic signed [PX_W-1:0]  gain_x_ff, gain_y_ff;
   logic [LUMA_W-1:0]       gain_luma_ff;

   logic                       rsp_vld_ff;
   logic [LUMA_W-1:0]          rsp_luma_ff;
   logic signed [CHROMA_W-1:0] rsp_yb_ff, rsp_rg_ff;
   logic signed [PX_W-1:0]     yb_sh, rg_sh;
   logic signed [CHROMA_W-1:0] yb_in, rg_in;

   assign adv            = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s3_vld_ff   <= 1'b0;
         vec_vld_ff  <= '0;
         rot_vld_ff  <= '0;
         gain_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else if (adv) begin
         s1_vld_ff   <= req_chan.valid;
         s2_vld_ff   <= s1_vld_ff;
         s3_vld_ff   <= s2_vld_ff;
         vec_vld_ff  <= {vec_vld_ff[N-1:0], s3_vld_ff};
         rot_vld_ff  <= {rot_vld_ff[N-1:0], vec_vld_ff[N]};
         gain_vld_ff <= rot_vld_ff[N];
         rsp_vld_ff  <= gain_vld_ff;
      end
   end

   // gamma lookup
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_r_ff <= GAMMA_ROM[req_chan.red_in];
         s1_g_ff <= GAMMA_ROM[req_chan.green_in];
         s1_b_ff <= GAMMA_ROM[req_chan.blue_in];
      end
   end

   // matrix products
   always_comb begin
      rg_sum    = {1'b0, s1_r_ff} + {1'b0, s1_g_ff};
      rg_diff   = $signed({1'b0, s1_r_ff}) - $signed({1'b0, s1_g_ff});
      s2_cyb_in = $signed({1'b0, rg_sum, 15'd0}) - $signed({1'b0, s1_b_ff, 16'd0});
      s2_crg_in = CRG_W'(rg_diff) * CRG_W'(CRG_COEF);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_lr_ff  <= PROD_W'(s1_r_ff) * PROD_W'(LUMA_COEF_R);
         s2_lg_ff  <= PROD_W'(s1_g_ff) * PROD_W'(LUMA_COEF_G);
         s2_lb_ff  <= PROD_W'(s1_b_ff) * PROD_W'(LUMA_COEF_B);
         s2_cyb_ff <= s2_cyb_in;
         s2_crg_ff <= s2_crg_in;
      end
   end

   // rounding back to the pixel format, guard bits added
   always_comb begin
      luma_sum = CYB_W'(s2_lr_ff) + CYB_W'(s2_lg_ff) + CYB_W'(s2_lb_ff)
               + CYB_W'(1 << (FRAC_BITS - 1));
      cyb_sum  = (s2_cyb_ff + CYB_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      crg_sum  = (s2_crg_ff + CRG_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      cyb_q    = cyb_sum[CHROMA_W-1:0];
      crg_q    = crg_sum[CHROMA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_luma_ff <= luma_sum[FRAC_BITS+LUMA_W-1:FRAC_BITS];
         s3_x0_ff   <= VEC_W'(cyb_q) <<< GUARD_BITS;
         s3_y0_ff   <= VEC_W'(crg_q) <<< GUARD_BITS;
      end
   end

   // quadrant pre-rotation for vectoring
   always_comb begin
      vec_in.x0   = s3_x0_ff;
      vec_in.y0   = s3_y0_ff;
      vec_in.luma = s3_luma_ff;
      if (s3_x0_ff < 0) begin
         if (s3_y0_ff >= 0) begin
            vec_in.x = s3_y0_ff;
            vec_in.y = -s3_x0_ff;
            vec_in.z = ANG_PI_2;
         end else begin
            vec_in.x = -s3_y0_ff;
            vec_in.y = s3_x0_ff;
            vec_in.z = -ANG_PI_2;
         end
      end else begin
         vec_in.x = s3_x0_ff;
         vec_in.y = s3_y0_ff;
         vec_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) vec_ff[0] <= vec_in;
   end

   for (genvar i = 0; i < N; i++) begin : g_vec
      cordic_type nxt;
      always_comb begin
         nxt = vec_ff[i];
         if (vec_ff[i].y >= 0) begin
            nxt.x = vec_ff[i].x + (vec_ff[i].y >>> i);
            nxt.y = vec_ff[i].y - (vec_ff[i].x >>> i);
            nxt.z = vec_ff[i].z + ATAN_Q30[i];
         end else begin
            nxt.x = vec_ff[i].x - (vec_ff[i].y >>> i);
            nxt.y = vec_ff[i].y + (vec_ff[i].x >>> i);
            nxt.z = vec_ff[i].z - ATAN_Q30[i];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) vec_ff[i+1] <= nxt;
      end
   end

   // angle remap as a rotation amount
   always_comb begin
      ang_abs  = (vec_ff[N].z < 0) ? -vec_ff[N].z : vec_ff[N].z;
      ang_over = (ANG_W+2)'(ang_abs) - (ANG_W+2)'(ANG_PI_3);
      ang_tri  = (ang_over <<< 1) + ang_over;
      if (ang_abs < ANG_PI_3) ang_d = (ANG_W+2)'(ang_abs) >>> 1;
      else ang_d = (ANG_W+2)'(ANG_PI_2) + (ang_tri >>> 2) - (ANG_W+2)'(ang_abs);
      rot_in      = vec_ff[N];
      rot_in.x    = vec_ff[N].x0;
      rot_in.y    = vec_ff[N].y0;
      rot_in.z    = (vec_ff[N].z < 0) ? -ang_d[ANG_W-1:0] : ang_d[ANG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) rot_ff[0] <= rot_in;
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      cordic_type nxt;
      always_comb begin
         nxt = rot_ff[i];
         if (rot_ff[i].z >= 0) begin
            nxt.x = rot_ff[i].x - (rot_ff[i].y >>> i);
            nxt.y = rot_ff[i].y + (rot_ff[i].x >>> i);
            nxt.z = rot_ff[i].z - ATAN_Q30[i];
         end else begin
            nxt.x = rot_ff[i].x + (rot_ff[i].y >>> i);
            nxt.y = rot_ff[i].y - (rot_ff[i].x >>> i);
            nxt.z = rot_ff[i].z + ATAN_Q30[i];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) rot_ff[i+1] <= nxt;
      end
   end

   // cordic gain correction
   always_ff @(posedge clock) begin
      if (adv) begin
         gain_x_ff    <= PX_W'(rot_ff[N].x) * PX_W'(GAIN_INV);
         gain_y_ff    <= PX_W'(rot_ff[N].y) * PX_W'(GAIN_INV);
         gain_luma_ff <= rot_ff[N].luma;
      end
   end

   always_comb begin
      yb_sh = (gain_x_ff + (PX_W'(1) <<< (29 + GUARD_BITS))) >>> (30 + GUARD_BITS);
      rg_sh = (gain_y_ff + (PX_W'(1) <<< (29 + GUARD_BITS))) >>> (30 + GUARD_BITS);
      if (yb_sh > PX_W'(CHROMA_MAX))      yb_in = CHROMA_MAX;
      else if (yb_sh < PX_W'(CHROMA_MIN)) yb_in = CHROMA_MIN;
      else                                yb_in = yb_sh[CHROMA_W-1:0];
      if (rg_sh > PX_W'(CHROMA_MAX))      rg_in = CHROMA_MAX;
      else if (rg_sh < PX_W'(CHROMA_MIN)) rg_in = CHROMA_MIN;
      else                                rg_in = rg_sh[CHROMA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_luma_ff <= gain_luma_ff;
         rsp_yb_ff   <= yb_in;
         rsp_rg_ff   <= rg_in;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.luma_out      = rsp_luma_ff;
   assign rsp_chan.chroma_yb_out = rsp_yb_ff;
   assign rsp_chan.chroma_rg_out = rsp_rg_ff;

   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> rsp_luma_ff <= LUMA_W'(1 << FRAC_BITS))
      else $error("luma above one");

   a_valid_follow: assert property (@(posedge clock)
      (!reset && adv) |=> (reset || rsp_vld_ff == $past(gain_vld_ff)))
      else $error("result valid lost or invented");

   a_remap_range: assert property (@(posedge clock) disable iff (reset)
      rot_vld_ff[0] |-> (rot_ff[0].z <= ANG_PI_6 && rot_ff[0].z >= -ANG_PI_6))
      else $error("remap rotation out of range");

endmodule

// ===== tb/sv/tb_rgb_to_orgb_pixel.sv =====
`timescale 1ns / 100ps

module tb_rgb_to_orgb_pixel;
   import r2o_pkg::*;

   localparam int STAGES    = 16;
   localparam int LATENCY   = 2 * STAGES + 7;
   localparam int N_RANDOM  = 1900;
   localparam longint Q30_PI_2 = 64'sd1686629713;
   localparam longint Q30_PI_3 = 64'sd1124419809;
   localparam longint Q30_GAIN = 64'sd652032874;
   localparam int GUARD     = 6;

   typedef struct {
      logic [LUMA_W-1:0]          luma;
      logic signed [CHROMA_W-1:0] yb;
      logic signed [CHROMA_W-1:0] rg;
   } orgb_word_type;

   typedef struct {
      logic [7:0]    r;
      logic [7:0]    g;
      logic [7:0]    b;
      bit            typed;
      orgb_word_type want;
   } pixel_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;

   logic [GAM_W-1:0] gamma_q16 [256];
   longint           arctan_q30 [STAGES];
   orgb_word_type    pending_words [$];

   r2o_req_if req_chan ();
   r2o_rsp_if rsp_chan ();

   rgb_to_orgb_pixel #(.CORDIC_STAGES(STAGES)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // (2y-1)^11 * 255^5 <= x^5 * 2^187 means y is not above the rounded gamma value
   function automatic bit gamma_fits(int x, int y);
      logic [255:0] lhs;
      logic [255:0] rhs;
      if (y == 0) return 1'b1;
      rhs = 256'd1;
      for (int k = 0; k < 5; k++) rhs = rhs * 256'(x);
      rhs = rhs << 187;
      lhs = 256'd1;
      for (int k = 0; k < 11; k++) lhs = lhs * 256'(2 * y - 1);
      for (int k = 0; k < 5; k++) lhs = lhs * 256'd255;
      return lhs <= rhs;
   endfunction

   task automatic fill_tables();
      int  y;
      real v;
      for (int x = 0; x < 256; x++) begin
         v = 65536.0 * ((x / 255.0) ** (5.0 / 11.0));
         y = int'($floor(v + 0.5));
         while (y < 65536 && gamma_fits(x, y + 1)) y++;
         while (y > 0 && !gamma_fits(x, y)) y--;
         gamma_q16[x] = GAM_W'(y);
      end
      arctan_q30 = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                     16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                     262143, 131071, 65535, 32767};
   endtask

   function automatic longint round_q(longint v, int k);
      return (v + (64'sd1 <<< (k - 1))) >>> k;
   endfunction

   function automatic longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic orgb_word_type orgb_of(logic [7:0] red, logic [7:0] green,
                                             logic [7:0] blue);
      orgb_word_type w;
      longint r, g, b, cyb, crg, x0, y0, vx, vy, ang, nx, ny, t, mag, turn, rx, ry;
      r = longint'(gamma_q16[red]);
      g = longint'(gamma_q16[green]);
      b = longint'(gamma_q16[blue]);
      w.luma = LUMA_W'(sat(round_q(19595 * r + 38470 * g + 7471 * b, 16), 0, 131071));
      cyb = round_q(32768 * (r + g) - 65536 * b, 16);
      crg = round_q(56754 * (r - g), 16);
      x0 = cyb <<< GUARD;
      y0 = crg <<< GUARD;
      vx = x0;
      vy = y0;
      ang = 0;
      if (vx < 0) begin
         t = vx;
         if (vy >= 0) begin
            vx = vy;
            vy = -t;
            ang = Q30_PI_2;
         end else begin
            vx = -vy;
            vy = t;
            ang = -Q30_PI_2;
         end
      end
      for (int i = 0; i < STAGES; i++) begin
         if (vy >= 0) begin
            nx = vx + (vy >>> i);
            ny = vy - (vx >>> i);
            ang += arctan_q30[i];
         end else begin
            nx = vx - (vy >>> i);
            ny = vy + (vx >>> i);
            ang -= arctan_q30[i];
         end
         vx = nx;
         vy = ny;
      end
      mag = ang < 0 ? -ang : ang;
      if (mag < Q30_PI_3) turn = mag >>> 1;
      else turn = Q30_PI_2 + ((3 * (mag - Q30_PI_3)) >>> 2) - mag;
      if (ang < 0) turn = -turn;
      rx = x0;
      ry = y0;
      for (int i = 0; i < STAGES; i++) begin
         if (turn >= 0) begin
            nx = rx - (ry >>> i);
            ny = ry + (rx >>> i);
            turn -= arctan_q30[i];
         end else begin
            nx = rx + (ry >>> i);
            ny = ry - (rx >>> i);
            turn += arctan_q30[i];
         end
         rx = nx;
         ry = ny;
      end
      w.yb = CHROMA_W'(sat(round_q(rx * Q30_GAIN, 30 + GUARD), -131072, 131071));
      w.rg = CHROMA_W'(sat(round_q(ry * Q30_GAIN, 30 + GUARD), -131072, 131071));
      return w;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             orgb_word_type want);
      int gap;
      req_chan.valid    <= 1'b1;
      req_chan.red_in   <= r;
      req_chan.green_in <= g;
      req_chan.blue_in  <= b;
      do @(posedge clock); while (!req_chan.ready);
      pending_words.push_back(want);
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   pixel_row_type rows [$];

   task automatic add_row(int r, int g, int b, bit typed = 0,
                          int l = 0, int yb = 0, int rg = 0);
      pixel_row_type row;
      row.r = 8'(r);
      row.g = 8'(g);
      row.b = 8'(b);
      row.typed = typed;
      row.want.luma = LUMA_W'(l);
      row.want.yb = CHROMA_W'(yb);
      row.want.rg = CHROMA_W'(rg);
      rows.push_back(row);
   endtask

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.red_in   = '0;
      req_chan.green_in = '0;
      req_chan.blue_in  = '0;
      fill_tables();
      // black, white and gray carry no chroma
      add_row(0, 0, 0, 1, 0, 0, 0);
      add_row(255, 255, 255, 1, 65536, 0, 0);
      add_row(128, 128, 128);
      add_row(1, 1, 1);
      add_row(255, 0, 0);
      add_row(0, 255, 0);
      add_row(0, 0, 255);
      add_row(255, 255, 0);
      add_row(0, 255, 255);
      add_row(255, 0, 255);
      // angle close to plus and minus pi, then other hues
      add_row(12, 0, 255);
      add_row(0, 12, 255);
      add_row(255, 0, 40);
      add_row(200, 40, 0);
      add_row(254, 1, 170);
      add_row(85, 170, 85);
      add_row(170, 85, 170);
      add_row(1, 254, 127);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i])
         send_pixel(rows[i].r, rows[i].g, rows[i].b,
                    rows[i].typed ? rows[i].want : orgb_of(rows[i].r, rows[i].g, rows[i].b));

      for (int n = 0; n < N_RANDOM; n++) begin
         logic [7:0] r, g, b;
         int kind;
         kind = $urandom_range(9);
         r = 8'($urandom_range(255));
         g = 8'($urandom_range(255));
         b = 8'($urandom_range(255));
         if (kind == 0) begin
            r = $urandom_range(1) ? 8'd255 : 8'd0;
            g = $urandom_range(1) ? 8'd255 : 8'd0;
            b = $urandom_range(1) ? 8'd255 : 8'd0;
         end else if (kind == 1) begin
            g = r + 8'($urandom_range(2)) - 8'd1;
            b = r + 8'($urandom_range(2)) - 8'd1;
         end
         send_pixel(r, g, b, orgb_of(r, g, b));
      end
      req_chan.valid <= 1'b0;

      wait (pending_words.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // result side back pressure, long open stretches mixed with stalls
   initial begin
      int run;
      int gap;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         run = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(12, 1);
         rsp_chan.ready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      orgb_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_words.size() == 0) begin
            report("unexpected word luma", longint'(rsp_chan.luma_out), 0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_chan.luma_out !== want.luma)
               report("luma_out", longint'(rsp_chan.luma_out), longint'(want.luma));
            if (rsp_chan.chroma_yb_out !== want.yb)
               report("chroma_yb_out", longint'(rsp_chan.chroma_yb_out), longint'(want.yb));
            if (rsp_chan.chroma_rg_out !== want.rg)
               report("chroma_rg_out", longint'(rsp_chan.chroma_rg_out), longint'(want.rg));
         end
      end
   end

   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
